>>> src/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the stack bytecode execute unit
// Holds opcode and status codes, payload structs and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package sbe_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int GLOBAL_COUNT = 256;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int GA_W  = $clog2(GLOBAL_COUNT);

    localparam logic [7:0] OP_CONST_INT   = 8'd0;
    localparam logic [7:0] OP_CONST_TRUE  = 8'd1;
    localparam logic [7:0] OP_CONST_FALSE = 8'd2;
    localparam logic [7:0] OP_ADD         = 8'd3;
    localparam logic [7:0] OP_SUB         = 8'd4;
    localparam logic [7:0] OP_MUL         = 8'd5;
    localparam logic [7:0] OP_DIV         = 8'd6;
    localparam logic [7:0] OP_EQ          = 8'd7;
    localparam logic [7:0] OP_LT          = 8'd8;
    localparam logic [7:0] OP_LOAD        = 8'd9;
    localparam logic [7:0] OP_STORE       = 8'd10;
    localparam logic [7:0] OP_JUMP        = 8'd11;
    localparam logic [7:0] OP_JUMP_IF_Z   = 8'd12;
    localparam logic [7:0] OP_PRINT       = 8'd13;
    localparam logic [7:0] OP_INPUT       = 8'd14;
    localparam logic [7:0] OP_POP         = 8'd15;
    localparam logic [7:0] OP_HALT        = 8'd16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_DIVZ    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_HALT    = 3'd4;
    localparam logic [2:0] ST_OVER    = 3'd5;
    localparam logic [2:0] ST_ADDR    = 3'd6;

    typedef struct packed {
        logic              req_type;
        logic              clear_globals;
        logic [7:0]        opcode;
        logic signed [31:0] immediate;
        logic [15:0]       pc_after;
        logic signed [31:0] input_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0]       next_pc;
        logic              print_valid;
        logic signed [31:0] print_value;
        logic [2:0]        status;
        logic [6:0]        stack_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture input item
        logic rd_top;      // capture stack[sp-1] into b, issue read of stack[sp-2]
        logic rd_a;        // read stack[sp-2] into a
        logic rd_glob;     // read global into r
        logic calc;        // compute result word
        logic div_start;   // start divider
        logic push;        // write r at stack[sp], sp+1
        logic bin_wr;      // write r at stack[sp-2], sp-1
        logic pop;         // sp-1
        logic glob_wr;     // write b into global
        logic clr_start;   // clear all global valid bits at once
        logic clr_step;    // not used by the datapath
        logic finish;      // build result from status
        logic [2:0] st;    // status to report on finish
        logic jump;        // use jump target
        logic print;       // print b
        logic start_run;   // start item: sp and fault cleared
    } ctl_cmd_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic        req_type;
        logic        clear_globals;
        logic        fault;
        logic        sp_lt1;
        logic        sp_lt2;
        logic        sp_full;
        logic        addr_bad;
        logic        b_zero;
        logic        div_done;
        logic        clr_done;
    } dp_status_t;

endpackage

>>> src/stack_bytecode_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit: execute unit of a 32-bit stack machine
// Top level joining the sequencing controller and the stack datapath.
// ----------------------------------------------------------------------------
// Usage: the fetcher offers one decoded instruction or start request per
// transaction on in_valid/in_ready with payload in_data. Every transaction
// yields exactly one result transaction on out_valid/out_ready (out_data).
// One item is in flight at a time, and the next one is accepted only after
// the result of the last one appears. Start, jump, halt, blocked items and
// faults found at decode go straight to the result; binary operations wait
// on the registered read port of the stack memory, and a divide that is
// not by zero also on the bit-serial divider.
// Globals are cleared at once by a start request with clear_globals set:
// each global has a valid bit and an entry not written since reads as zero.
// After reset the stack is empty, the fault flag is clear and all globals
// read zero. When the receiver stalls, the result stays in the output
// register; one more transaction is accepted and carried up to its result
// stage, where it waits, and the input then stalls until the result is taken.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sbe_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sbe_pkg::out_item_t out_data
);

    sbe_pkg::ctl_cmd_t   cmd;
    sbe_pkg::dp_status_t stat;

    sbe_controller u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sbe_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .res     (out_data)
    );

endmodule

>>> src/sbe_divider.sv
// ----------------------------------------------------------------------------
// sbe_divider: signed 32-bit divider
// Restoring radix-2 divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module sbe_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

>>> src/sbe_datapath.sv
// ----------------------------------------------------------------------------
// sbe_datapath: stack memory, global memory and ALU
// Holds the operand stack, the globals, the stack pointer, the fault flag and
// the output register.
// ----------------------------------------------------------------------------
module sbe_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbe_pkg::in_item_t in_item,
    input  sbe_pkg::ctl_cmd_t cmd,
    output sbe_pkg::dp_status_t stat,
    output sbe_pkg::out_item_t  res
);

    logic [31:0] stack_mem [sbe_pkg::STACK_DEPTH];
    logic [31:0] glob_mem  [sbe_pkg::GLOBAL_COUNT];
    logic [sbe_pkg::GLOBAL_COUNT-1:0] gvalid_reg;

    sbe_pkg::in_item_t item_reg;
    logic [sbe_pkg::SP_W-1:0] sp_reg, sp_next;
    logic        fault_reg, fault_next;
    logic [31:0] a_reg, b_reg, r_reg;
    logic [31:0] stack_rd, glob_rd;
    logic        gv_rd;
    logic [63:0] prod;
    logic        div_done;
    logic [31:0] div_q;
    logic [sbe_pkg::SA_W-1:0] rd_addr;
    logic [sbe_pkg::GA_W-1:0] gidx;
    logic [15:0] idx;
    sbe_pkg::out_item_t res_reg;

    assign idx  = item_reg.immediate[15:0];
    assign gidx = idx[sbe_pkg::GA_W-1:0];
    // The top word is read during decode; while it is captured, the word below
    // it is read for the second operand.
    assign rd_addr = (cmd.rd_a || cmd.rd_top)
                   ? sbe_pkg::SA_W'(sp_reg - sbe_pkg::SP_W'(2))
                   : sbe_pkg::SA_W'(sp_reg - sbe_pkg::SP_W'(1));

    sbe_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_item;
        stack_rd <= stack_mem[rd_addr];
        if (cmd.push)
            stack_mem[sbe_pkg::SA_W'(sp_reg)] <= r_reg;
        else if (cmd.bin_wr)
            stack_mem[sbe_pkg::SA_W'(sp_reg - sbe_pkg::SP_W'(2))] <= r_reg;
        glob_rd <= glob_mem[gidx];
        gv_rd   <= gvalid_reg[gidx];
        if (cmd.glob_wr)
            glob_mem[gidx] <= b_reg;
        if (cmd.rd_top)
            b_reg <= stack_rd;
        if (cmd.rd_a)
            a_reg <= stack_rd;
        prod <= 64'(a_reg) * 64'(b_reg);
        if (cmd.rd_glob)
            r_reg <= gv_rd ? glob_rd : 32'd0;
        else if (cmd.calc)
        begin
            case (item_reg.opcode)
                sbe_pkg::OP_ADD:        r_reg <= a_reg + b_reg;
                sbe_pkg::OP_SUB:        r_reg <= a_reg - b_reg;
                sbe_pkg::OP_MUL:        r_reg <= prod[31:0];
                sbe_pkg::OP_DIV:        r_reg <= div_q;
                sbe_pkg::OP_EQ:         r_reg <= {31'd0, a_reg == b_reg};
                sbe_pkg::OP_LT:         r_reg <= {31'd0, $signed(a_reg) < $signed(b_reg)};
                sbe_pkg::OP_CONST_INT:  r_reg <= item_reg.immediate;
                sbe_pkg::OP_CONST_TRUE: r_reg <= 32'd1;
                sbe_pkg::OP_INPUT:      r_reg <= item_reg.input_value;
                default:                r_reg <= 32'd0;
            endcase
        end
    end

    // Global valid bits stand in for a memory-wide clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gvalid_reg <= '0;
        else if (cmd.clr_start)
            gvalid_reg <= '0;
        else if (cmd.glob_wr)
            gvalid_reg[gidx] <= 1'b1;
    end

    always_comb
    begin
        sp_next    = sp_reg;
        fault_next = fault_reg;
        if (cmd.start_run)
        begin
            sp_next    = '0;
            fault_next = 1'b0;
        end
        else if (cmd.push)
            sp_next = sp_reg + sbe_pkg::SP_W'(1);
        else if (cmd.bin_wr || cmd.pop)
            sp_next = sp_reg - sbe_pkg::SP_W'(1);
        if (cmd.finish && cmd.st != sbe_pkg::ST_OK && !item_reg.req_type)
            fault_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            sp_reg    <= sp_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg.status      <= cmd.st;
            res_reg.stack_count <= 7'(sp_next);
            res_reg.print_valid <= cmd.print;
            res_reg.print_value <= cmd.print ? b_reg : 32'd0;
            if (item_reg.req_type)
                res_reg.next_pc <= 16'd0;
            else if (cmd.jump)
                res_reg.next_pc <= idx;
            else
                res_reg.next_pc <= item_reg.pc_after;
        end
    end

    assign res = res_reg;

    always_comb
    begin
        stat.opcode        = item_reg.opcode;
        stat.req_type      = item_reg.req_type;
        stat.clear_globals = item_reg.clear_globals;
        stat.fault         = fault_reg;
        stat.sp_lt1        = (sp_reg < sbe_pkg::SP_W'(1));
        stat.sp_lt2        = (sp_reg < sbe_pkg::SP_W'(2));
        stat.sp_full       = (sp_reg >= sbe_pkg::SP_W'(sbe_pkg::STACK_DEPTH));
        stat.addr_bad      = (32'(idx) >= 32'(sbe_pkg::GLOBAL_COUNT));
        stat.b_zero        = (b_reg == 32'd0);
        stat.div_done      = div_done;
        stat.clr_done      = 1'b1;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.sp_full)
        else $error("push into a full stack");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bin_wr |-> !stat.sp_lt2)
        else $error("binary write with fewer than two operands");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.sp_lt1)
        else $error("pop of an empty stack");

endmodule

>>> src/sbe_controller.sv
// ----------------------------------------------------------------------------
// sbe_controller: sequencing state machine
// Steps each item through stack reads, compute and write-back, and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module sbe_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sbe_pkg::dp_status_t stat,
    output sbe_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_B, S_RD_A, S_WAIT_A, S_MUL, S_DIV, S_CALC,
        S_GLOB, S_WRITE, S_DONE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [2:0] st_reg, st_next;
    logic   jump_reg, jump_next, print_reg, print_next;
    logic   binop, pushop, popop;

    assign binop  = stat.opcode inside {[sbe_pkg::OP_ADD:sbe_pkg::OP_LT]};
    assign pushop = stat.opcode inside {sbe_pkg::OP_CONST_INT, sbe_pkg::OP_CONST_TRUE,
                                        sbe_pkg::OP_CONST_FALSE, sbe_pkg::OP_LOAD,
                                        sbe_pkg::OP_INPUT};
    assign popop  = stat.opcode inside {sbe_pkg::OP_STORE, sbe_pkg::OP_JUMP_IF_Z,
                                        sbe_pkg::OP_PRINT, sbe_pkg::OP_POP};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        st_next        = st_reg;
        jump_next      = jump_reg;
        print_next     = print_reg;
        cmd            = '0;
        cmd.st         = st_reg;
        cmd.jump       = jump_reg;
        cmd.print      = print_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                st_next    = sbe_pkg::ST_OK;
                jump_next  = 1'b0;
                print_next = 1'b0;
                state_next = S_DONE;
                if (stat.req_type)
                begin
                    cmd.start_run = 1'b1;
                    cmd.clr_start = stat.clear_globals;
                end
                else if (stat.fault)
                    st_next = sbe_pkg::ST_HALT;
                else if (binop)
                begin
                    if (stat.sp_lt2) st_next = sbe_pkg::ST_UNDER;
                    else state_next = S_RD_B;
                end
                else if (pushop)
                begin
                    if (stat.opcode == sbe_pkg::OP_LOAD && stat.addr_bad)
                        st_next = sbe_pkg::ST_ADDR;
                    else if (stat.sp_full)
                        st_next = sbe_pkg::ST_OVER;
                    else if (stat.opcode == sbe_pkg::OP_LOAD)
                        state_next = S_GLOB;
                    else
                        state_next = S_CALC;
                end
                else if (popop)
                begin
                    if (stat.sp_lt1) st_next = sbe_pkg::ST_UNDER;
                    else if (stat.opcode == sbe_pkg::OP_STORE && stat.addr_bad)
                        st_next = sbe_pkg::ST_ADDR;
                    else state_next = S_RD_B;
                end
                else if (stat.opcode == sbe_pkg::OP_JUMP)
                    jump_next = 1'b1;
                else if (stat.opcode == sbe_pkg::OP_HALT)
                    st_next = sbe_pkg::ST_HALT;
                else
                    st_next = sbe_pkg::ST_UNKNOWN;
            end
            S_RD_B:
            begin
                // Read data of stack[sp-1] is available now; the read of
                // stack[sp-2] is issued in the same cycle.
                cmd.rd_top = 1'b1;
                if (binop)
                    state_next = S_RD_A;
                else
                    state_next = S_WAIT_A;
            end
            S_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                if (binop)
                begin
                    if (stat.opcode == sbe_pkg::OP_DIV)
                    begin
                        if (stat.b_zero)
                        begin
                            st_next    = sbe_pkg::ST_DIVZ;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    else
                        state_next = S_MUL;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    if (stat.opcode == sbe_pkg::OP_STORE) cmd.glob_wr = 1'b1;
                    if (stat.opcode == sbe_pkg::OP_PRINT) print_next = 1'b1;
                    if (stat.opcode == sbe_pkg::OP_JUMP_IF_Z) jump_next = stat.b_zero;
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                state_next = S_CALC;
            end
            S_DIV:
            begin
                if (stat.div_done) state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_WRITE;
            end
            S_GLOB:
            begin
                cmd.rd_glob = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                if (binop) cmd.bin_wr = 1'b1;
                else cmd.push = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Waits here while an earlier result is still held.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            st_reg        <= sbe_pkg::ST_OK;
            jump_reg      <= 1'b0;
            print_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            jump_reg      <= jump_next;
            print_reg     <= print_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction did not start decode");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished transaction produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

>>> test/sbe_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_result_checker: result predictor and scoreboard for the execute unit
// Watches both channels, keeps a shadow copy of the stack machine state and
// compares every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module sbe_result_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  sbe_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  sbe_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending_count
);

    logic [31:0]        shadow_stack [sbe_pkg::STACK_DEPTH];
    logic [31:0]        shadow_globals [sbe_pkg::GLOBAL_COUNT];
    int                 shadow_sp;
    logic               shadow_fault;
    sbe_pkg::out_item_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic [31:0] quotient_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // Advances the shadow state by one transaction and returns its result.
    function automatic sbe_pkg::out_item_t execute_item(sbe_pkg::in_item_t it);
        sbe_pkg::out_item_t res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [15:0] idx;
        logic [7:0]  op;
        a = '0;
        b = '0;
        r = '0;
        idx = it.immediate[15:0];
        op = it.opcode;
        res = '0;
        res.next_pc = it.pc_after;
        res.status = sbe_pkg::ST_OK;
        if (it.req_type)
        begin
            shadow_sp = 0;
            shadow_fault = 1'b0;
            if (it.clear_globals)
                foreach (shadow_globals[i]) shadow_globals[i] = '0;
            res.next_pc = '0;
        end
        else if (shadow_fault)
            res.status = sbe_pkg::ST_HALT;
        else
        begin
            if (op >= sbe_pkg::OP_ADD && op <= sbe_pkg::OP_LT)
            begin
                if (shadow_sp < 2)
                    res.status = sbe_pkg::ST_UNDER;
                else
                begin
                    a = shadow_stack[shadow_sp - 2];
                    b = shadow_stack[shadow_sp - 1];
                    case (op)
                        sbe_pkg::OP_ADD: r = a + b;
                        sbe_pkg::OP_SUB: r = a - b;
                        sbe_pkg::OP_MUL: r = a * b;
                        sbe_pkg::OP_DIV:
                            if (b == 0) res.status = sbe_pkg::ST_DIVZ;
                            else r = quotient_trunc(a, b);
                        sbe_pkg::OP_EQ:  r = {31'd0, a == b};
                        default: r = {31'd0, $signed(a) < $signed(b)};
                    endcase
                    if (res.status == sbe_pkg::ST_OK)
                    begin
                        shadow_stack[shadow_sp - 2] = r;
                        shadow_sp--;
                    end
                end
            end
            else if (op <= sbe_pkg::OP_CONST_FALSE || op == sbe_pkg::OP_LOAD
                     || op == sbe_pkg::OP_INPUT)
            begin
                if (op == sbe_pkg::OP_CONST_INT) r = it.immediate;
                else if (op == sbe_pkg::OP_CONST_TRUE) r = 1;
                else if (op == sbe_pkg::OP_CONST_FALSE) r = 0;
                else if (op == sbe_pkg::OP_INPUT) r = it.input_value;
                else if (idx >= sbe_pkg::GLOBAL_COUNT) res.status = sbe_pkg::ST_ADDR;
                else r = shadow_globals[idx];
                if (res.status == sbe_pkg::ST_OK)
                begin
                    if (shadow_sp >= sbe_pkg::STACK_DEPTH)
                        res.status = sbe_pkg::ST_OVER;
                    else
                    begin
                        shadow_stack[shadow_sp] = r;
                        shadow_sp++;
                    end
                end
            end
            else if (op == sbe_pkg::OP_STORE || op == sbe_pkg::OP_JUMP_IF_Z
                     || op == sbe_pkg::OP_PRINT || op == sbe_pkg::OP_POP)
            begin
                if (shadow_sp < 1)
                    res.status = sbe_pkg::ST_UNDER;
                else
                begin
                    r = shadow_stack[shadow_sp - 1];
                    if (op == sbe_pkg::OP_STORE)
                    begin
                        if (idx >= sbe_pkg::GLOBAL_COUNT) res.status = sbe_pkg::ST_ADDR;
                        else shadow_globals[idx] = r;
                    end
                    else if (op == sbe_pkg::OP_JUMP_IF_Z)
                    begin
                        if (r == 0) res.next_pc = idx;
                    end
                    else if (op == sbe_pkg::OP_PRINT)
                    begin
                        res.print_valid = 1'b1;
                        res.print_value = r;
                    end
                    if (res.status == sbe_pkg::ST_OK)
                        shadow_sp--;
                end
            end
            else if (op == sbe_pkg::OP_JUMP)
                res.next_pc = idx;
            else if (op == sbe_pkg::OP_HALT)
                res.status = sbe_pkg::ST_HALT;
            else
                res.status = sbe_pkg::ST_UNKNOWN;
            if (res.status != sbe_pkg::ST_OK)
            begin
                shadow_fault = 1'b1;
                res.next_pc = it.pc_after;
                res.print_valid = 1'b0;
                res.print_value = '0;
            end
        end
        res.stack_count = shadow_sp[6:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sbe_pkg::out_item_t want;
        if (!rst_n)
        begin
            shadow_sp = 0;
            shadow_fault = 1'b0;
            foreach (shadow_globals[i]) shadow_globals[i] = '0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results = {expected_results, execute_item(in_data)};
            // A result is never taken in the cycle in which its own input is accepted,
            // so queueing before comparing keeps the order right.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", longint'(out_data.status), 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.next_pc !== want.next_pc)
                        report_mismatch("next_pc", out_data.next_pc, want.next_pc);
                    if (out_data.print_valid !== want.print_valid)
                        report_mismatch("print_valid", out_data.print_valid, want.print_valid);
                    if (out_data.print_value !== want.print_value)
                        report_mismatch("print_value", out_data.print_value, want.print_value);
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.stack_count !== want.stack_count)
                        report_mismatch("stack_count", out_data.stack_count, want.stack_count);
                end
            end
        end
    end

endmodule

>>> test/tb_stack_bytecode_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_bytecode_execute_unit: regression bench of the stack execute unit
// Drives directed and random instruction streams, built mostly from programs
// that keep the stack healthy, through several idling phases, and lets the
// checker compare every result transaction with its prediction.
// ----------------------------------------------------------------------------
module tb_stack_bytecode_execute_unit;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    sbe_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    sbe_pkg::out_item_t out_data;
    int                 fail_count;
    int                 pending_count;

    // Idling percentages of each side; the stimulus changes them by phase.
    int  send_idle_pct;
    int  recv_stall_pct;
    // When set, the receiver holds off completely for a long stretch.
    bit  recv_hold;
    int  cycle_count = 0;

    // Software view of the stack depth, used only to steer stimulus.
    int  depth_guess;

    stack_bytecode_execute_unit uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    sbe_result_checker checker_i
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // The receiver decides its ready afresh at every edge. During a hold it
    // stays low for the whole stretch so that the unit backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: far above the slowest legal run (divides with long stalls).
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one transaction and waits for it to be taken. Valid stays high
    // after acceptance when the next transaction follows at once; it is
    // lowered at the first idle edge.
    task automatic send_item(sbe_pkg::in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic sbe_pkg::in_item_t make_instr(logic [7:0] op, logic [31:0] imm);
        sbe_pkg::in_item_t it;
        it.req_type      = 1'b0;
        it.clear_globals = 1'($urandom_range(1));
        it.opcode        = op;
        it.immediate     = imm;
        it.pc_after      = 16'($urandom);
        it.input_value   = $urandom;
        return it;
    endfunction

    task automatic run_instr(logic [7:0] op, logic [31:0] imm);
        send_item(make_instr(op, imm));
    endtask

    task automatic run_start(logic clear);
        sbe_pkg::in_item_t it;
        it = make_instr(sbe_pkg::OP_CONST_INT, $urandom);
        it.req_type = 1'b1;
        it.clear_globals = clear;
        it.opcode = 8'($urandom);
        send_item(it);
        depth_guess = 0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // Global index: mostly in range, always with junk in the high half.
    function automatic logic [31:0] pick_index();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(15) != 0)
            v[15:0] = 16'($urandom_range(sbe_pkg::GLOBAL_COUNT - 1));
        return v;
    endfunction

    // One well-formed instruction chosen for the current depth, so that
    // faults stay rare and the stack goes up and down across its range.
    task automatic run_healthy_instr();
        int pick;
        logic [31:0] divisor;
        pick = $urandom_range(99);
        if (depth_guess < 2 || (pick < 35 && depth_guess < sbe_pkg::STACK_DEPTH))
        begin
            case ($urandom_range(4))
                0: run_instr(sbe_pkg::OP_CONST_TRUE, $urandom);
                1: run_instr(sbe_pkg::OP_CONST_FALSE, $urandom);
                2: run_instr(sbe_pkg::OP_INPUT, $urandom);
                3: run_instr(sbe_pkg::OP_LOAD, pick_index());
                default: run_instr(sbe_pkg::OP_CONST_INT, pick_value());
            endcase
            depth_guess++;
        end
        else if (pick < 75)
        begin
            if ($urandom_range(9) == 0)
            begin
                // Divide with a nonzero divisor on top, or a subtract when the stack is full.
                divisor = pick_value();
                if (divisor == 0) divisor = 32'hffff_ffff;
                if (depth_guess < sbe_pkg::STACK_DEPTH)
                begin
                    run_instr(sbe_pkg::OP_CONST_INT, divisor);
                    run_instr(sbe_pkg::OP_DIV, $urandom);
                end
                else
                begin
                    run_instr(sbe_pkg::OP_SUB, $urandom);
                    depth_guess--;
                end
            end
            else
            begin
                case ($urandom_range(4))
                    0: run_instr(sbe_pkg::OP_ADD, $urandom);
                    1: run_instr(sbe_pkg::OP_SUB, $urandom);
                    2: run_instr(sbe_pkg::OP_MUL, $urandom);
                    3: run_instr(sbe_pkg::OP_EQ, $urandom);
                    default: run_instr(sbe_pkg::OP_LT, $urandom);
                endcase
                depth_guess--;
            end
        end
        else if (pick < 95)
        begin
            case ($urandom_range(3))
                0: run_instr(sbe_pkg::OP_STORE, pick_index());
                1: run_instr(sbe_pkg::OP_JUMP_IF_Z, $urandom);
                2: run_instr(sbe_pkg::OP_PRINT, $urandom);
                default: run_instr(sbe_pkg::OP_POP, $urandom);
            endcase
            depth_guess--;
        end
        else
            run_instr(sbe_pkg::OP_JUMP, $urandom);
    endtask

    // Any opcode, any field values: mostly faults and unknown opcodes.
    task automatic run_noise_instr();
        logic [7:0] op;
        op = ($urandom_range(1) == 0) ? 8'($urandom)
                                      : 8'($urandom_range(sbe_pkg::OP_HALT));
        run_instr(op, $urandom);
        depth_guess = -1000;
    endtask

    // A random program: a start, then healthy instructions with some noise.
    task automatic run_program(int n);
        run_start(1'($urandom_range(1)));
        repeat (n)
        begin
            if (depth_guess < 0 || $urandom_range(99) < 5)
            begin
                run_start(1'($urandom_range(1)));
            end
            else if ($urandom_range(99) < 4)
                run_noise_instr();
            else
                run_healthy_instr();
        end
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        depth_guess = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, most opcodes, and each special case.
        run_instr(sbe_pkg::OP_ADD, 0);                      // underflow on empty stack
        run_instr(sbe_pkg::OP_CONST_INT, 0);                // blocked after a fault
        run_start(1'b0);
        run_instr(sbe_pkg::OP_CONST_INT, 32'h8000_0000);
        run_instr(sbe_pkg::OP_CONST_INT, 32'hffff_ffff);
        run_instr(sbe_pkg::OP_DIV, 0);                      // most negative over -1
        run_instr(sbe_pkg::OP_CONST_INT, 32'h7fff_ffff);
        run_instr(sbe_pkg::OP_LT, 0);
        run_instr(sbe_pkg::OP_STORE, 32'hffff_00ff);        // highest valid index
        run_instr(sbe_pkg::OP_LOAD, 32'h0000_00ff);
        run_instr(sbe_pkg::OP_CONST_FALSE, 0);
        run_instr(sbe_pkg::OP_DIV, 0);                      // divide by zero
        run_start(1'b1);
        run_instr(sbe_pkg::OP_CONST_TRUE, 0);
        run_instr(sbe_pkg::OP_STORE, 32'h0000_ffff);        // bad address on store
        run_start(1'b0);
        run_instr(sbe_pkg::OP_STORE, 32'h0000_0100);        // underflow before address
        run_start(1'b0);
        run_instr(sbe_pkg::OP_LOAD, 32'h0000_0100);         // bad address on load
        run_start(1'b0);
        run_instr(sbe_pkg::OP_INPUT, 0);
        run_instr(sbe_pkg::OP_JUMP_IF_Z, 32'h0000_ffff);
        run_instr(sbe_pkg::OP_JUMP, 32'hffff_1234);
        run_instr(8'hff, 0);                                // unknown opcode
        run_start(1'b0);
        run_instr(sbe_pkg::OP_HALT, 0);
        wait_drained();

        // Fill to the top, then overflow, and empty through print, pop, branch and multiply.
        run_start(1'b0);
        repeat (sbe_pkg::STACK_DEPTH) run_instr(sbe_pkg::OP_CONST_INT, pick_value());
        run_instr(sbe_pkg::OP_LOAD, 0);                     // overflow after address check
        run_start(1'b0);
        repeat (sbe_pkg::STACK_DEPTH) run_instr(sbe_pkg::OP_CONST_INT, pick_value());
        repeat (sbe_pkg::STACK_DEPTH / 4)
        begin
            run_instr(sbe_pkg::OP_PRINT, 0);
            run_instr(sbe_pkg::OP_POP, 0);
            run_instr(sbe_pkg::OP_JUMP_IF_Z, $urandom);
            run_instr(sbe_pkg::OP_MUL, 0);
        end
        depth_guess = 0;
        wait_drained();

        // Random phases with different idling on each side.
        run_program(300);
        send_idle_pct = 84;
        run_program(250);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        run_program(250);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        run_program(250);

        // Sender pauses until everything is back, then the receiver holds
        // off while the sender keeps offering, so the input stalls.
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            run_program(40);
        join
        run_program(100);

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
